### design/vir_pkg.sv
// Shared types, codes and reply tables of the inquiry responder.
`timescale 1ns / 1ps
`default_nettype none

package vir_pkg;

    localparam logic [7:0] BYTE_TERM  = 8'hFF;
    localparam logic [7:0] START_MARK = 8'h80;

    typedef enum logic [2:0] {
        RPL_POWER   = 3'd0,
        RPL_ID      = 3'd1,
        RPL_MODEL   = 3'd2,
        RPL_VERSION = 3'd3,
        RPL_ZOOM    = 3'd4,
        RPL_FOCUS   = 3'd5
    } reply_code_t;

    // One reply waiting to be sent.
    typedef struct packed {
        reply_code_t code;
        logic [2:0]  addr;
    } reply_job_t;

    typedef struct packed {
        logic       push;
        reply_job_t job;
    } push_req_t;

    // Bytes after the header, terminator included.
    function automatic logic [3:0] reply_len(input reply_code_t code);
        logic [3:0] len;
        len = 4'd0;
        unique case (code)
            RPL_POWER:   len = 4'd3;
            RPL_ID:      len = 4'd6;
            RPL_MODEL:   len = 4'd7;
            RPL_VERSION: len = 4'd9;
            RPL_ZOOM:    len = 4'd6;
            RPL_FOCUS:   len = 4'd6;
            default:     len = 4'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] reply_body(input reply_code_t code, input logic [3:0] idx);
        logic [8:0][7:0] row;
        logic [7:0]      b;
        row = '0;
        unique case (code)
            RPL_POWER:   row = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                8'hFF, 8'h02, 8'h50};
            RPL_ID:      row = {8'h00, 8'h00, 8'h00, 8'hFF, 8'h01, 8'h08,
                                8'h01, 8'h08, 8'h50};
            RPL_MODEL:   row = {8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h52,
                                8'h7E, 8'h00, 8'h50};
            RPL_VERSION: row = {8'hFF, 8'h00, 8'h23, 8'h01, 8'h67, 8'h04,
                                8'h78, 8'h00, 8'h50};
            RPL_ZOOM:    row = {8'h00, 8'h00, 8'h00, 8'hFF, 8'h01, 8'h08,
                                8'h02, 8'h01, 8'h50};
            RPL_FOCUS:   row = {8'h00, 8'h00, 8'h00, 8'hFF, 8'h0A, 8'h01,
                                8'h00, 8'h01, 8'h50};
            default:     row = '0;
        endcase
        if (idx <= 4'd8)
        begin
            b = row[idx];
        end
        else
        begin
            b = 8'h00;
        end
        return b;
    endfunction

endpackage

`default_nettype wire

### design/vir_if.sv
// Handshake channels: received bytes in, reply bytes out.
`timescale 1ns / 1ps
`default_nettype none

interface vir_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       chunk_end;

    modport source (output valid, output rx_byte, output chunk_end, input ready);
    modport sink   (input valid, input rx_byte, input chunk_end, output ready);
endinterface

interface vir_reply_if;
    logic       valid;
    logic       ready;
    logic [7:0] reply_byte;
    logic       reply_last;

    modport source (output valid, output reply_byte, output reply_last, input ready);
    modport sink   (input valid, input reply_byte, input reply_last, output ready);
endinterface

`default_nettype wire

### design/vir_front.sv
// Packet parser: finds start byte, keeps body prefix, matches inquiries.
`timescale 1ns / 1ps
`default_nettype none

module vir_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [2:0]        dev_addr,
    input  wire logic              accept,
    input  wire logic [7:0]        rx_byte,
    input  wire logic              chunk_end,
    output vir_pkg::push_req_t     push_req
);

    localparam logic [23:0] KEY_POWER   = 24'h090400;
    localparam logic [23:0] KEY_ID      = 24'h090422;
    localparam logic [23:0] KEY_MODEL   = 24'h090037;
    localparam logic [23:0] KEY_VERSION = 24'h090002;
    localparam logic [23:0] KEY_ZOOM    = 24'h090447;
    localparam logic [23:0] KEY_FOCUS   = 24'h090448;

    logic             in_packet_reg, in_packet_next;
    logic [1:0]       body_count_reg, body_count_next;
    logic [7:0]       body_reg [3];
    logic [23:0]      key;
    logic             hit;
    vir_pkg::reply_code_t hit_code;
    logic [7:0]       start_byte;
    logic             is_term;

    assign start_byte = vir_pkg::START_MARK | {5'b00000, dev_addr};
    assign is_term    = (rx_byte == vir_pkg::BYTE_TERM);
    assign key        = {body_reg[0], body_reg[1], body_reg[2]};

    // keys are distinct, at most one hits
    always_comb
    begin
        hit      = 1'b1;
        hit_code = vir_pkg::RPL_POWER;
        priority if (key == KEY_POWER)   hit_code = vir_pkg::RPL_POWER;
        else if (key == KEY_ID)          hit_code = vir_pkg::RPL_ID;
        else if (key == KEY_MODEL)       hit_code = vir_pkg::RPL_MODEL;
        else if (key == KEY_VERSION)     hit_code = vir_pkg::RPL_VERSION;
        else if (key == KEY_ZOOM)        hit_code = vir_pkg::RPL_ZOOM;
        else if (key == KEY_FOCUS)       hit_code = vir_pkg::RPL_FOCUS;
        else                             hit      = 1'b0;
    end

    always_comb
    begin
        in_packet_next  = in_packet_reg;
        body_count_next = body_count_reg;
        push_req.push     = 1'b0;
        push_req.job.code = hit_code;
        push_req.job.addr = dev_addr;
        if (accept)
        begin
            if (!in_packet_reg)
            begin
                if (rx_byte == start_byte)
                begin
                    in_packet_next  = 1'b1;
                    body_count_next = 2'd0;
                end
            end
            else if (is_term)
            begin
                push_req.push   = (body_count_reg == 2'd3) && hit;
                in_packet_next  = 1'b0;
                body_count_next = 2'd0;
            end
            else if (body_count_reg != 2'd3)
            begin
                body_count_next = body_count_reg + 2'd1;
            end
            if (chunk_end)
            begin
                in_packet_next  = 1'b0;
                body_count_next = 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_packet_reg  <= 1'b0;
            body_count_reg <= 2'd0;
        end
        else
        begin
            in_packet_reg  <= in_packet_next;
            body_count_reg <= body_count_next;
        end
    end

    // body prefix store
    always_ff @(posedge clk)
    begin
        if (accept && in_packet_reg && !is_term && body_count_reg != 2'd3)
        begin
            body_reg[body_count_reg] <= rx_byte;
        end
    end

    a_count_in_packet: assert property (@(posedge clk) disable iff (!rst_n)
        (body_count_reg != 2'd0) |-> in_packet_reg)
        else $error("body count set outside a packet");

    a_chunk_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && chunk_end) |=> (!in_packet_reg && body_count_reg == 2'd0))
        else $error("partial packet survived chunk end");

endmodule

`default_nettype wire

### design/vir_queue.sv
// Small FIFO of pending replies between parser and emitter.
`timescale 1ns / 1ps
`default_nettype none

module vir_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire vir_pkg::push_req_t  push_req,
    output logic                     full,
    output logic                     q_valid,
    output vir_pkg::reply_job_t      q_job,
    input  wire logic                pop
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    vir_pkg::reply_job_t  slot_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]     count_reg;
    logic                 do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_job   = slot_reg[rd_ptr_reg];
    assign do_push = push_req.push && !full;
    assign do_pop  = pop && q_valid;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_req.job;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push_req.push |-> !full)
        else $error("reply pushed into full queue");

endmodule

`default_nettype wire

### design/vir_back.sv
// Emitter: walks one canned reply a byte per cycle unless held, to an output reg.
`timescale 1ns / 1ps
`default_nettype none

module vir_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_valid,
    input  wire vir_pkg::reply_job_t  q_job,
    output logic                      pop,
    vir_reply_if.source               tx
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_BODY = 2'b10
    } state_t;

    state_t               state_reg, state_next;
    vir_pkg::reply_code_t code_reg, code_next;
    logic [3:0]           idx_reg, idx_next;
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           out_byte_reg, out_byte_next;
    logic                 out_last_reg, out_last_next;
    logic                 advance;
    logic                 at_end;

    assign advance = !out_valid_reg || tx.ready;
    assign at_end  = (idx_reg == vir_pkg::reply_len(code_reg) - 4'd1);

    always_comb
    begin
        state_next     = state_reg;
        code_next      = code_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        pop            = 1'b0;
        if (advance)
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    out_valid_next = q_valid;
                    out_byte_next  = vir_pkg::START_MARK | {1'b0, q_job.addr, 4'b0000};
                    out_last_next  = 1'b0;
                    if (q_valid)
                    begin
                        pop        = 1'b1;
                        code_next  = q_job.code;
                        idx_next   = 4'd0;
                        state_next = ST_BODY;
                    end
                end
                ST_BODY:
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = vir_pkg::reply_body(code_reg, idx_reg);
                    out_last_next  = at_end;
                    idx_next       = idx_reg + 4'd1;
                    if (at_end)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                default:
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg     <= code_next;
        idx_reg      <= idx_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign tx.valid      = out_valid_reg;
    assign tx.reply_byte = out_byte_reg;
    assign tx.reply_last = out_last_reg;

    a_last_is_term: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> (out_byte_reg == vir_pkg::BYTE_TERM))
        else $error("reply end marked on a non-terminator byte");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == ST_IDLE && q_valid))
        else $error("queue popped while a reply is in progress");

endmodule

`default_nettype wire

### design/visca_inquiry_responder.sv
// Top level of the camera-side inquiry responder.
//
// Usage:
//   rx_in    : received serial bytes, one item per byte (rx_byte, chunk_end).
//              An item is taken at a clock edge with valid and ready high.
//   reply_out: reply bytes, header first; reply_last flags the closing 0xFF.
//   APB port : one register, device_address (bits 2:0 at byte address 0),
//              reset value 1. Write it only while the block is idle.
// Throughput: one received byte per cycle. ready drops only while the reply
//   queue holds QUEUE_DEPTH pending replies; reply bytes leave back to back
//   while reply_out.ready is high, with the next queued reply following on.
// Reply path: the terminating 0xFF of the inquiry is written into the queue
//   at the edge that takes it; the output register then loads the header
//   when the emitter is idle and the output is not held.
// Stalls: when reply_out.ready is low the output register holds its byte;
//   the parser keeps taking bytes until the queue fills.
// Reset: rst_n (async, active low) drops any partial packet, empties the
//   queue and the output register, and sets the address back to 1.
`timescale 1ns / 1ps
`default_nettype none

module visca_inquiry_responder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    vir_rx_if.sink           rx_in,
    vir_reply_if.source      reply_out
);

    logic [2:0]           dev_addr_reg;
    logic                 cfg_wr;
    logic                 accept;
    logic                 q_full;
    logic                 q_valid;
    logic                 q_pop;
    vir_pkg::push_req_t   push_req;
    vir_pkg::reply_job_t  q_job;

    // config register: only register 0 exists, upper word address ignored
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : {29'd0, dev_addr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg <= 3'd1;
        end
        else if (cfg_wr)
        begin
            dev_addr_reg <= pwdata[2:0];
        end
    end

    // front end stalls only when no queue slot is left
    assign rx_in.ready = !q_full;
    assign accept      = rx_in.valid && !q_full;

    vir_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .dev_addr  (dev_addr_reg),
        .accept    (accept),
        .rx_byte   (rx_in.rx_byte),
        .chunk_end (rx_in.chunk_end),
        .push_req  (push_req)
    );

    vir_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_req (push_req),
        .full     (q_full),
        .q_valid  (q_valid),
        .q_job    (q_job),
        .pop      (q_pop)
    );

    vir_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_job   (q_job),
        .pop     (q_pop),
        .tx      (reply_out)
    );

endmodule

`default_nettype wire
